/* design/xmodem_checksum_receiver_defines.svh */
// Assertion macros used by the receiver's back part (xcr_back).
`ifndef XMODEM_CHECKSUM_RECEIVER_DEFINES_SVH
`define XMODEM_CHECKSUM_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define XCR_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("xcr assertion failed");

// Next-cycle implication.
`define XCR_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("xcr assertion failed");

`else

`define XCR_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define XCR_ASSERT_NEXT(lbl, clk, rst_n, pre, post)

`endif

`endif

/* design/xcr_pkg.sv */
`timescale 1ns / 1ps

package xcr_pkg;

	localparam logic [7:0] BYTE_SOH = 8'h01;
	localparam logic [7:0] BYTE_EOT = 8'h04;

	// Frame layout: SOH at 0, number at 1, complement at 2, data 3..130, checksum 131.
	localparam int DATA_LEN  = 128;
	localparam int FRAME_LEN = 132;
	localparam logic [7:0] POS_NUMBER = 8'd1;
	localparam logic [7:0] POS_COMPL  = 8'd2;
	localparam logic [7:0] POS_DATA   = 8'd3;
	localparam logic [7:0] POS_CHECK  = 8'(FRAME_LEN - 1);

	localparam int WORD_BYTES = 8;
	localparam int WORDS      = DATA_LEN / WORD_BYTES;
	localparam int WORD_AW    = $clog2(WORDS);
	localparam int BANKS      = 2;
	localparam int MEM_AW     = WORD_AW + 1;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	localparam logic REPLY_ACK = 1'b0;
	localparam logic REPLY_NAK = 1'b1;

	// Command codes passed from front to back.
	localparam logic [1:0] CMD_NAK     = 2'd0;
	localparam logic [1:0] CMD_ACK_EOT = 2'd1;
	localparam logic [1:0] CMD_FRAME   = 2'd2;

	typedef struct packed {
		logic [1:0] code;
		logic       bank;
	} xcr_cmd_t;

	typedef struct packed {
		logic              en;
		logic [MEM_AW-1:0] addr;
		logic [63:0]       data;
	} xcr_wr_t;

	typedef struct packed {
		logic en;
		logic bank;
	} xcr_rel_t;

endpackage

/* design/xcr_front.sv */
`timescale 1ns / 1ps

module xcr_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] rx_byte
	input  logic             s_tuser,   // [0] kind
	input  logic             q_full,
	output logic             push,
	output xcr_pkg::xcr_cmd_t cmd,
	output xcr_pkg::xcr_wr_t  wr,
	input  xcr_pkg::xcr_rel_t rel
);
	import xcr_pkg::*;

	localparam logic [1:0] PH_DONE    = 2'd0;
	localparam logic [1:0] PH_HUNT    = 2'd1;
	localparam logic [1:0] PH_COLLECT = 2'd2;

	logic [1:0]       phase_q, phase_d;
	logic             faf_q, faf_d;
	logic [7:0]       pos_q, pos_d;
	logic [7:0]       blk_q, blk_d;
	logic [7:0]       cmp_q, cmp_d;
	logic [7:0]       sum_q, sum_d;
	logic [7:0]       last_q, last_d;
	logic             bank_q, bank_d;
	logic [BANKS-1:0] busy_q, busy_d;
	logic [55:0]      wbuf_q, wbuf_d;

	logic       accept;
	logic       in_data;
	logic [7:0] didx;
	logic       good;

	assign in_data = (phase_q == PH_COLLECT) && (pos_q >= POS_DATA) && (pos_q < POS_CHECK);
	// Hold off data bytes bound for a bank the back part is still draining.
	assign s_tready = !q_full && !(in_data && busy_q[bank_q]);
	assign accept = s_tvalid && s_tready;
	assign didx = pos_q - POS_DATA;
	assign good = (s_tdata == sum_q) && (blk_q == ~cmp_q)
		&& ((blk_q == 8'(last_q + 8'd1)) || (blk_q == last_q));

	always_comb begin
		phase_d = phase_q;
		faf_d = faf_q;
		pos_d = pos_q;
		blk_d = blk_q;
		cmp_d = cmp_q;
		sum_d = sum_q;
		last_d = last_q;
		bank_d = bank_q;
		busy_d = busy_q;
		wbuf_d = wbuf_q;
		push = 1'b0;
		cmd = '{code: CMD_NAK, bank: bank_q};
		wr = '{en: 1'b0, addr: {bank_q, didx[6:3]}, data: {wbuf_q, s_tdata}};
		if (rel.en) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (accept) begin
			if (!s_tuser) begin
				phase_d = PH_HUNT;
				faf_d = 1'b1;
				pos_d = '0;
				blk_d = '0;
				cmp_d = '0;
				sum_d = '0;
				last_d = '0;
				push = 1'b1;
			end else begin
				unique case (phase_q)
					PH_HUNT: begin
						if (s_tdata == BYTE_EOT && faf_q) begin
							phase_d = PH_DONE;
							faf_d = 1'b0;
							push = 1'b1;
							cmd.code = CMD_ACK_EOT;
						end else begin
							faf_d = 1'b0;
							if (s_tdata == BYTE_SOH) begin
								phase_d = PH_COLLECT;
								pos_d = POS_NUMBER;
								sum_d = '0;
							end
						end
					end
					PH_COLLECT: begin
						if (pos_q == POS_NUMBER) begin
							blk_d = s_tdata;
							pos_d = pos_q + 8'd1;
						end else if (pos_q == POS_COMPL) begin
							cmp_d = s_tdata;
							pos_d = pos_q + 8'd1;
						end else if (in_data) begin
							wbuf_d = {wbuf_q[47:0], s_tdata};
							sum_d = sum_q + s_tdata;
							pos_d = pos_q + 8'd1;
							// Write the word once its eighth byte is in.
							wr.en = (didx[2:0] == 3'd7);
						end else begin
							phase_d = PH_HUNT;
							faf_d = 1'b1;
							pos_d = '0;
							push = 1'b1;
							if (good) begin
								cmd.code = CMD_FRAME;
								busy_d[bank_q] = 1'b1;
								bank_d = !bank_q;
								last_d = blk_q;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DONE;
			faf_q <= 1'b0;
			pos_q <= '0;
			blk_q <= '0;
			cmp_q <= '0;
			sum_q <= '0;
			last_q <= '0;
			bank_q <= 1'b0;
			busy_q <= '0;
		end else begin
			phase_q <= phase_d;
			faf_q <= faf_d;
			pos_q <= pos_d;
			blk_q <= blk_d;
			cmp_q <= cmp_d;
			sum_q <= sum_d;
			last_q <= last_d;
			bank_q <= bank_d;
			busy_q <= busy_d;
		end
	end

	always_ff @(posedge clk) begin
		wbuf_q <= wbuf_d;
	end

endmodule

/* design/xcr_queue.sv */
`timescale 1ns / 1ps

module xcr_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  xcr_pkg::xcr_cmd_t wdata,
	output logic              full,
	input  logic              pop,
	output xcr_pkg::xcr_cmd_t head,
	output logic              empty
);
	import xcr_pkg::*;

	xcr_cmd_t       entries_q [QDEPTH];
	logic [QAW-1:0] wptr_q, rptr_q;
	logic [QAW:0]   count_q;
	logic           do_push, do_pop;

	assign full = (count_q == (QAW+1)'(QDEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign head = entries_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/xcr_back.sv */
`timescale 1ns / 1ps

`include "xmodem_checksum_receiver_defines.svh"

module xcr_back (
	input  logic              clk,
	input  logic              arst_n,
	input  xcr_pkg::xcr_cmd_t head,
	input  logic              q_empty,
	output logic              pop,
	input  xcr_pkg::xcr_wr_t  wr,
	output xcr_pkg::xcr_rel_t rel,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [71:0]       m_tdata,  // [0] reply_code, [64:1] payload_word, [65] transfer_done
	output logic              m_tuser,  // [0] is_reply
	output logic              m_tlast
);
	import xcr_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_WR   = 2'd2;
	localparam logic [1:0] S_ACK  = 2'd3;

	logic [63:0]        mem_q [BANKS*WORDS];
	logic [63:0]        rd_q;
	logic [1:0]         state_q, state_d;
	logic               bank_q, bank_d;
	logic [WORD_AW-1:0] cnt_q, cnt_d;
	logic               ov_q, ov_d;
	logic               ouser_q, ouser_d;
	logic               olast_q, olast_d;
	logic [71:0]        odata_q, odata_d;
	logic               out_free;

	assign out_free = !ov_q || m_tready;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rd_q <= mem_q[{bank_q, cnt_q}];
	end

	always_comb begin
		state_d = state_q;
		bank_d = bank_q;
		cnt_d = cnt_q;
		ouser_d = ouser_q;
		olast_d = olast_q;
		odata_d = odata_q;
		ov_d = ov_q && !m_tready;
		pop = 1'b0;
		rel = '{en: 1'b0, bank: bank_q};
		unique case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					if (head.code == CMD_FRAME) begin
						pop = 1'b1;
						bank_d = head.bank;
						cnt_d = '0;
						state_d = S_RD;
					end else if (out_free) begin
						pop = 1'b1;
						ov_d = 1'b1;
						ouser_d = 1'b1;
						olast_d = 1'b1;
						odata_d = '0;
						odata_d[0] = (head.code == CMD_NAK) ? REPLY_NAK : REPLY_ACK;
						odata_d[65] = (head.code == CMD_ACK_EOT);
					end
				end
			end
			S_RD: begin
				// Read address settles this cycle; data is registered next.
				state_d = S_WR;
			end
			S_WR: begin
				if (out_free) begin
					ov_d = 1'b1;
					ouser_d = 1'b0;
					olast_d = 1'b0;
					odata_d = {7'd0, rd_q, REPLY_ACK};
					if (cnt_q == WORD_AW'(WORDS - 1)) begin
						state_d = S_ACK;
					end else begin
						cnt_d = cnt_q + 1'b1;
						state_d = S_RD;
					end
				end
			end
			S_ACK: begin
				if (out_free) begin
					ov_d = 1'b1;
					ouser_d = 1'b1;
					olast_d = 1'b1;
					odata_d = '0;
					odata_d[0] = REPLY_ACK;
					rel.en = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			bank_q <= 1'b0;
			cnt_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			bank_q <= bank_d;
			cnt_q <= cnt_d;
			ov_q <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		ouser_q <= ouser_d;
		olast_q <= olast_d;
		odata_q <= odata_d;
	end

	assign m_tvalid = ov_q;
	assign m_tuser = ouser_q;
	assign m_tlast = olast_q;
	assign m_tdata = odata_q;

	`XCR_ASSERT_IMPL(a_word_not_last, clk, arst_n, m_tvalid && !m_tuser, !m_tlast)
	`XCR_ASSERT_NEXT(a_read_then_load, clk, arst_n, state_q == S_RD, state_q == S_WR)
	`XCR_ASSERT_NEXT(a_frame_ack, clk, arst_n, state_q == S_ACK && out_free, m_tvalid && m_tuser && m_tlast && m_tdata[0] == REPLY_ACK)

endmodule

/* design/xmodem_checksum_receiver.sv */
// Input: one byte a cycle; stalls only when the command queue is full or data for
// the next frame would land in a bank whose words are still being sent.
// A reply (start NAK, EOT ACK, bad-frame NAK) passes through the command queue and a registered output.
// A good frame drains as 16 payload words, each read (S_RD) and then sent (S_WR), then an ACK.
// Reset: asynchronous, active low; clears control state, frame memory is not cleared.
`timescale 1ns / 1ps

module xmodem_checksum_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [0] reply_code, [64:1] payload_word, [65] transfer_done
	output logic        m_tuser,   // [0] is_reply
	output logic        m_tlast
);
	import xcr_pkg::*;

	logic     q_full, q_empty, push, pop;
	xcr_cmd_t cmd, head;
	xcr_wr_t  wr;
	xcr_rel_t rel;

	xcr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (push),
		.cmd      (cmd),
		.wr       (wr),
		.rel      (rel)
	);

	xcr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd),
		.full   (q_full),
		.pop    (pop),
		.head   (head),
		.empty  (q_empty)
	);

	xcr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.q_empty  (q_empty),
		.pop      (pop),
		.wr       (wr),
		.rel      (rel),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
